/* src/q24_8_fixed_point_alu_core_assert.svh */
// Assertion macros for the Q24.8 fixed-point ALU core.
// Sampled on clk and disabled while rst_n is low; empty under SYNTHESIS.
`ifndef Q24_8_FIXED_POINT_ALU_CORE_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define Q24ALU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an expression is never true at a clock edge outside reset.
`define Q24ALU_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define Q24ALU_ASSERT(label, prop, msg)
`define Q24ALU_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* src/q24alu_pkg.sv */
// Shared constants, types and helpers for the Q24.8 fixed-point ALU.
// No dependencies; used by the channel interfaces and the core.
package q24alu_pkg;

    // Datapath shape
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int PORT_BITS = 32;
    localparam int CMD_BITS  = 4;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;

    // Command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_FROM_INT = 4'd8,
        CMD_TO_INT   = 4'd9
    } cmd_t;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PORT_BITS-1:0] port_word_t;
    typedef logic        [WORD_BITS-1:0] mag_t;
    typedef logic        [DIV_BITS-1:0]  dvd_t;

    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
    } flags_t;

    // Cut a port word to the datapath width
    function automatic word_t wrap_in(port_word_t v);
        return v[WORD_BITS-1:0];
    endfunction

    // Sign-extend a datapath word to the port width
    function automatic port_word_t widen(word_t v);
        return PORT_BITS'(v);
    endfunction

endpackage

/* src/q24alu_op_if.sv */
// Operation channel of the Q24.8 ALU: command and two operands.
// Depends on q24alu_pkg for field widths.
interface q24alu_op_if;
    logic                                valid;
    logic                                ready;
    logic [q24alu_pkg::CMD_BITS-1:0]     command;
    logic signed [q24alu_pkg::PORT_BITS-1:0] operand_a;
    logic signed [q24alu_pkg::PORT_BITS-1:0] operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

/* src/q24alu_res_if.sv */
// Result channel of the Q24.8 ALU: result word and comparison flags.
// Depends on q24alu_pkg for field widths.
interface q24alu_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [q24alu_pkg::PORT_BITS-1:0] result_value;
    logic                                    a_less;
    logic                                    a_equal;
    logic                                    a_greater;
    logic                                    divide_by_zero;

    modport source (output valid, output result_value, output a_less, output a_equal,
                    output a_greater, output divide_by_zero, input ready);
    modport sink   (input valid, input result_value, input a_less, input a_equal,
                    input a_greater, input divide_by_zero, output ready);
endinterface

/* src/q24_8_fixed_point_alu_core.sv */
// Q24.8 fixed-point ALU core: fully pipelined, one op per clock unless held.
// Depends on q24alu_pkg, q24alu_op_if, q24alu_res_if and the assert header.
//
// Takes one item per cycle while the skid register is empty and returns one
// result item per item, in order. An item passes through the input register,
// the execute stage, the DIV_BITS divider stages and the output register. A
// result that waits at the output holds every item behind it. Every command
// passes through the divider stages, a restoring divider with one quotient bit
// per pipeline stage over the DIV_BITS-bit shifted dividend. All other commands
// finish in the second stage and ride along with the divider. The whole
// pipeline holds while a result waits at the output; a one-item skid register
// keeps operation.ready registered and accepts one item during such a hold.
// Division by zero returns 0 with divide_by_zero set; all results wrap to the
// word width, and unused command codes return 0.
`include "q24_8_fixed_point_alu_core_assert.svh"

module q24_8_fixed_point_alu_core (
    input  logic                clk,
    input  logic                rst_n,
    q24alu_op_if.sink           operation,
    q24alu_res_if.source        result
);
    import q24alu_pkg::*;

    // Pipeline advance: everything moves unless a result is held at the output
    logic adv;

    // Skid register in front of the pipeline
    logic                    skid_valid_reg;
    logic [CMD_BITS-1:0]     skid_cmd_reg;
    port_word_t              skid_opa_reg;
    port_word_t              skid_opb_reg;
    logic                    src_valid;
    logic [CMD_BITS-1:0]     src_cmd;
    port_word_t              src_opa;
    port_word_t              src_opb;

    // Input register stage
    logic                    in_valid_reg;
    cmd_t                    in_cmd_reg;
    word_t                   in_opa_reg;
    word_t                   in_opb_reg;

    // Execute stage results
    word_t                   res_next;
    flags_t                  flags_next;
    logic                    dz_next;
    logic                    div_next;
    logic                    neg_next;
    dvd_t                    dvd_next;
    mag_t                    dvs_next;
    logic signed [PROD_BITS-1:0] prod;
    mag_t                    opa_mag;

    // Stage 0 is the execute stage, stages 1..DIV_BITS are divider steps
    logic [DIV_BITS:0]       p_valid_reg;
    word_t                   p_res_reg   [0:DIV_BITS];
    flags_t                  p_flags_reg [0:DIV_BITS];
    logic                    p_dz_reg    [0:DIV_BITS];
    logic                    p_div_reg   [0:DIV_BITS];
    logic                    p_neg_reg   [0:DIV_BITS];
    mag_t                    p_rem_reg   [0:DIV_BITS];
    dvd_t                    p_dvq_reg   [0:DIV_BITS];
    mag_t                    p_dvs_reg   [0:DIV_BITS];

    // One restoring step per stage
    mag_t                    step_rem [0:DIV_BITS-1];
    logic [DIV_BITS-1:0]     step_bit;

    // Output register
    logic                    out_valid_reg;
    word_t                   out_value_next;
    dvd_t                    quot_signed;
    port_word_t              out_value_reg;
    flags_t                  out_flags_reg;
    logic                    out_dz_reg;

    assign adv = !out_valid_reg || result.ready;

    // Skid buffer: take an item while stalled, release it on the next advance
    assign operation.ready = !skid_valid_reg;
    assign src_valid = skid_valid_reg || operation.valid;
    assign src_cmd   = skid_valid_reg ? skid_cmd_reg : operation.command;
    assign src_opa   = skid_valid_reg ? skid_opa_reg : operation.operand_a;
    assign src_opb   = skid_valid_reg ? skid_opb_reg : operation.operand_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (operation.valid && operation.ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (operation.ready)
        begin
            skid_cmd_reg <= operation.command;
            skid_opa_reg <= operation.operand_a;
            skid_opb_reg <= operation.operand_b;
        end
    end

    // Execute: simple ops, flags, multiply and divider setup
    always_comb
    begin
        prod    = PROD_BITS'(in_opa_reg) * PROD_BITS'(in_opb_reg);
        opa_mag = in_opa_reg[WORD_BITS-1] ? mag_t'(-in_opa_reg) : mag_t'(in_opa_reg);

        flags_next.less    = in_opa_reg < in_opb_reg;
        flags_next.equal   = in_opa_reg == in_opb_reg;
        flags_next.greater = in_opa_reg > in_opb_reg;

        dz_next  = (in_cmd_reg == CMD_DIV) && (in_opb_reg == '0);
        div_next = (in_cmd_reg == CMD_DIV) && (in_opb_reg != '0);
        neg_next = in_opa_reg[WORD_BITS-1] ^ in_opb_reg[WORD_BITS-1];
        dvd_next = {opa_mag, {FRAC_BITS{1'b0}}};
        dvs_next = in_opb_reg[WORD_BITS-1] ? mag_t'(-in_opb_reg) : mag_t'(in_opb_reg);

        unique case (in_cmd_reg)
            CMD_ADD:      res_next = in_opa_reg + in_opb_reg;
            CMD_SUB:      res_next = in_opa_reg - in_opb_reg;
            CMD_MUL:      res_next = prod[FRAC_BITS +: WORD_BITS];
            CMD_DIV:      res_next = '0;
            CMD_MIN:      res_next = flags_next.less ? in_opa_reg : in_opb_reg;
            CMD_MAX:      res_next = flags_next.less ? in_opb_reg : in_opa_reg;
            CMD_INC:      res_next = in_opa_reg + word_t'(1);
            CMD_DEC:      res_next = in_opa_reg - word_t'(1);
            CMD_FROM_INT: res_next = in_opa_reg <<< FRAC_BITS;
            CMD_TO_INT:   res_next = in_opa_reg >>> FRAC_BITS;
            default:      res_next = '0;
        endcase
    end

    // Divider steps: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        logic [WORD_BITS:0] rem_sh;
        logic [WORD_BITS:0] trial;
        rem_sh = '0;
        trial  = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            rem_sh      = {p_rem_reg[j], p_dvq_reg[j][DIV_BITS-1]};
            trial       = rem_sh - {1'b0, p_dvs_reg[j]};
            step_bit[j] = rem_sh >= {1'b0, p_dvs_reg[j]};
            step_rem[j] = step_bit[j] ? trial[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
        end
    end

    // Apply the quotient sign and pick the final result word
    always_comb
    begin
        quot_signed = p_neg_reg[DIV_BITS] ? -p_dvq_reg[DIV_BITS] : p_dvq_reg[DIV_BITS];
        if (p_div_reg[DIV_BITS])
        begin
            out_value_next = quot_signed[WORD_BITS-1:0];
        end
        else
        begin
            out_value_next = p_res_reg[DIV_BITS];
        end
    end

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            p_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= src_valid;
            p_valid_reg   <= {p_valid_reg[DIV_BITS-1:0], in_valid_reg};
            out_valid_reg <= p_valid_reg[DIV_BITS];
        end
    end

    // Advance payload through every stage together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_cmd_reg <= cmd_t'(src_cmd);
            in_opa_reg <= wrap_in(src_opa);
            in_opb_reg <= wrap_in(src_opb);

            p_res_reg[0]   <= res_next;
            p_flags_reg[0] <= flags_next;
            p_dz_reg[0]    <= dz_next;
            p_div_reg[0]   <= div_next;
            p_neg_reg[0]   <= neg_next;
            p_rem_reg[0]   <= '0;
            p_dvq_reg[0]   <= dvd_next;
            p_dvs_reg[0]   <= dvs_next;

            for (int k = 1; k <= DIV_BITS; k++)
            begin
                p_res_reg[k]   <= p_res_reg[k-1];
                p_flags_reg[k] <= p_flags_reg[k-1];
                p_dz_reg[k]    <= p_dz_reg[k-1];
                p_div_reg[k]   <= p_div_reg[k-1];
                p_neg_reg[k]   <= p_neg_reg[k-1];
                p_rem_reg[k]   <= step_rem[k-1];
                p_dvq_reg[k]   <= {p_dvq_reg[k-1][DIV_BITS-2:0], step_bit[k-1]};
                p_dvs_reg[k]   <= p_dvs_reg[k-1];
            end

            out_value_reg <= widen(out_value_next);
            out_flags_reg <= p_flags_reg[DIV_BITS];
            out_dz_reg    <= p_dz_reg[DIV_BITS];
        end
    end

    // Drive the result channel from the output register
    assign result.valid          = out_valid_reg;
    assign result.result_value   = out_value_reg;
    assign result.a_less         = out_flags_reg.less;
    assign result.a_equal        = out_flags_reg.equal;
    assign result.a_greater      = out_flags_reg.greater;
    assign result.divide_by_zero = out_dz_reg;

    // Exactly one comparison flag per result
    `Q24ALU_ASSERT(a_flags_onehot,
        result.valid |-> $onehot({result.a_less, result.a_equal, result.a_greater}),
        "comparison flags not one-hot")

    // Division by zero always returns zero
    `Q24ALU_ASSERT(a_dz_zero,
        result.valid && result.divide_by_zero |-> result.result_value == '0,
        "divide by zero with nonzero result")

    // A held pipeline keeps its valid bits
    `Q24ALU_ASSERT(a_hold_valid,
        !adv |=> $stable(p_valid_reg) && $stable(in_valid_reg),
        "stage valid bits moved during a hold")

    // The skid register only fills while the pipeline is held
    `Q24ALU_ASSERT(a_skid_fill,
        $rose(skid_valid_reg) |-> $past(!adv),
        "skid register filled while the pipeline advanced")

endmodule

/* tb/q24_8_fixed_point_alu_core_tb.sv */
`timescale 1ns / 1ps
// Testbench for the Q24.8 fixed-point ALU core: directed edge cases, then random items
// with or without input gaps and result stalls, checked against an in-bench predictor.
// Depends on q24alu_pkg, q24alu_op_if, q24alu_res_if and q24_8_fixed_point_alu_core.
module q24_8_fixed_point_alu_core_tb;
    import q24alu_pkg::*;

    localparam int CMD_CODES   = 1 << CMD_BITS;
    localparam int LATENCY     = DIV_BITS + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [PORT_BITS-1:0] W_MIN  = {1'b1, {(PORT_BITS-1){1'b0}}};
    localparam logic signed [PORT_BITS-1:0] W_MAX  = {1'b0, {(PORT_BITS-1){1'b1}}};
    localparam logic signed [PORT_BITS-1:0] FX_ONE = 1 <<< FRAC_BITS;

    typedef enum int {
        RECV_FREE,
        RECV_MIXED,
        RECV_HEAVY
    } recv_mode_t;

    typedef struct packed {
        logic [PORT_BITS-1:0] value;
        logic                 less;
        logic                 equal;
        logic                 greater;
        logic                 div_zero;
    } alu_out_t;

    logic clk;
    logic rst_n;

    q24alu_op_if  op_ch ();
    q24alu_res_if res_ch ();

    q24_8_fixed_point_alu_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (op_ch),
        .result    (res_ch)
    );

    alu_out_t   pending_results[$];
    int         mismatch_count;
    int         checked_count;
    int         cycle_count;
    int         items_sent;
    int         div_zero_sent;
    int         code_seen[CMD_CODES];
    int         burst_left;
    bit         gaps_on;
    recv_mode_t recv_mode;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cut a value to the datapath width and sign-extend it
    function automatic longint to_word(longint v);
        logic signed [WORD_BITS-1:0] w;
        w = v[WORD_BITS-1:0];
        return longint'(w);
    endfunction

    // Compute the expected result item for one operation
    function automatic alu_out_t predict_alu(logic [CMD_BITS-1:0] code,
                                             logic signed [PORT_BITS-1:0] a_in,
                                             logic signed [PORT_BITS-1:0] b_in);
        alu_out_t exp;
        longint   a;
        longint   b;
        longint   r;
        logic     dz;
        a  = to_word(a_in);
        b  = to_word(b_in);
        r  = 0;
        dz = 1'b0;
        case (code)
            CMD_ADD:      r = a + b;
            CMD_SUB:      r = a - b;
            CMD_MUL:      r = (a * b) >>> FRAC_BITS;
            CMD_DIV:
            begin
                if (b == 0)
                    dz = 1'b1;
                else
                    r = (a * (longint'(1) <<< FRAC_BITS)) / b;
            end
            CMD_MIN:      r = (a < b) ? a : b;
            CMD_MAX:      r = (a >= b) ? a : b;
            CMD_INC:      r = a + 1;
            CMD_DEC:      r = a - 1;
            CMD_FROM_INT: r = a * (longint'(1) <<< FRAC_BITS);
            CMD_TO_INT:   r = a >>> FRAC_BITS;
            default:      r = 0;
        endcase
        r = to_word(r);
        exp.value    = r[PORT_BITS-1:0];
        exp.less     = (a < b);
        exp.equal    = (a == b);
        exp.greater  = (a > b);
        exp.div_zero = dz;
        return exp;
    endfunction

    // Send one item, idling between bursts, and record its expected result
    task automatic send_op(input logic [CMD_BITS-1:0] code,
                           input logic signed [PORT_BITS-1:0] a,
                           input logic signed [PORT_BITS-1:0] b);
        if (gaps_on && burst_left == 0)
        begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        op_ch.valid     <= 1'b1;
        op_ch.command   <= code;
        op_ch.operand_a <= a;
        op_ch.operand_b <= b;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_alu(code, a, b));
        items_sent++;
        code_seen[code]++;
        if (code == CMD_DIV && to_word(b) == 0)
            div_zero_sent++;
    endtask

    // Hold the input idle until every expected result has come back
    task automatic drain_results();
        op_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Pick an operand: extremes, small magnitudes or full-range values
    function automatic logic signed [PORT_BITS-1:0] pick_operand();
        logic signed [PORT_BITS-1:0] v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       v = W_MIN;
                    1:       v = W_MAX;
                    2:       v = '0;
                    3:       v = -1;
                    4:       v = FX_ONE;
                    default: v = -FX_ONE;
                endcase
            end
            1, 2:    v = $signed($urandom_range(0, 4095)) - 2048;
            3:       v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Pick a command, mostly defined ones and now and then an unused code
    function automatic logic [CMD_BITS-1:0] pick_command();
        if ($urandom_range(0, 15) == 0)
            return CMD_BITS'($urandom_range(CMD_TO_INT + 1, CMD_CODES - 1));
        return CMD_BITS'($urandom_range(CMD_ADD, CMD_TO_INT));
    endfunction

    // Send random items; b sometimes copies a so the equal flag gets exercised
    task automatic send_random(input int count);
        logic [CMD_BITS-1:0]         code;
        logic signed [PORT_BITS-1:0] a;
        logic signed [PORT_BITS-1:0] b;
        repeat (count)
        begin
            code = pick_command();
            a    = pick_operand();
            b    = ($urandom_range(0, 7) == 0) ? a : pick_operand();
            send_op(code, a, b);
        end
    endtask

    // Edge cases: wrap on add, sub, mul, div, inc, dec and from-int, rounding
    // direction, divide by zero, equal operands and unused codes
    task automatic test_edge_cases();
        recv_mode = RECV_MIXED;
        gaps_on   = 1'b1;
        send_op(CMD_ADD, W_MAX, 1);
        send_op(CMD_ADD, W_MIN, W_MIN);
        send_op(CMD_SUB, W_MIN, 1);
        send_op(CMD_MUL, W_MAX, W_MAX);
        send_op(CMD_MUL, -1, 1);
        send_op(CMD_MUL, FX_ONE + (FX_ONE >>> 1), -FX_ONE);
        send_op(CMD_MUL, W_MIN, W_MIN);
        send_op(CMD_DIV, FX_ONE, 0);
        send_op(CMD_DIV, W_MIN, -1);
        send_op(CMD_DIV, -7, 2);
        send_op(CMD_DIV, W_MAX, 1);
        send_op(CMD_MIN, W_MIN, W_MAX);
        send_op(CMD_MAX, W_MAX, W_MAX);
        send_op(CMD_MIN, 5, 5);
        send_op(CMD_INC, W_MAX, 0);
        send_op(CMD_DEC, W_MIN, 0);
        send_op(CMD_FROM_INT, W_MAX, W_MIN);
        send_op(CMD_TO_INT, -1, 0);
        send_op(CMD_TO_INT, W_MIN, W_MAX);
        for (int c = CMD_TO_INT + 1; c < CMD_CODES; c++)
            send_op(CMD_BITS'(c), pick_operand(), pick_operand());
        drain_results();
    endtask

    // Random items with bursty input and a varying result-side stall pattern
    task automatic test_random_mix();
        recv_mode = RECV_MIXED;
        gaps_on   = 1'b1;
        send_random(650);
        drain_results();
    endtask

    // Back-to-back items with the result side always ready
    task automatic test_full_rate();
        recv_mode  = RECV_FREE;
        gaps_on    = 1'b0;
        burst_left = 0;
        send_random(150);
        drain_results();
    endtask

    // Heavy result-side stalls so the pipeline holds and the skid fills
    task automatic test_output_stall();
        recv_mode = RECV_HEAVY;
        gaps_on   = 1'b1;
        send_random(150);
        drain_results();
    endtask

    // Result-side ready: pattern windows of random length in mixed mode
    initial
    begin : recv_drive
        int window_left;
        int pattern;
        int phase;
        window_left = 0;
        pattern     = 0;
        phase       = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (window_left == 0)
            begin
                window_left = $urandom_range(16, 200);
                pattern     = $urandom_range(0, 3);
                phase       = 0;
            end
            window_left--;
            phase++;
            case (recv_mode)
                RECV_FREE:  res_ch.ready <= 1'b1;
                RECV_HEAVY: res_ch.ready <= ($urandom_range(0, 7) == 0);
                default:
                begin
                    case (pattern)
                        0:       res_ch.ready <= 1'b1;
                        1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
                        2:       res_ch.ready <= (phase % 5) > 1;
                        default: res_ch.ready <= (phase % 48) >= 30;
                    endcase
                end
            endcase
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            alu_out_t got;
            alu_out_t exp;
            got.value    = res_ch.result_value;
            got.less     = res_ch.a_less;
            got.equal    = res_ch.a_equal;
            got.greater  = res_ch.a_greater;
            got.div_zero = res_ch.divide_by_zero;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result item value=%h flags lt/eq/gt/dz=%b%b%b%b",
                             got.value, got.less, got.equal, got.greater, got.div_zero);
            end
            else
            begin
                exp = pending_results.pop_front();
                checked_count++;
                if (got.value !== exp.value || got.less !== exp.less ||
                    got.equal !== exp.equal || got.greater !== exp.greater ||
                    got.div_zero !== exp.div_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: result %0d value exp=%h got=%h lt/eq/gt/dz exp=%b%b%b%b got=%b%b%b%b",
                                 checked_count, exp.value, got.value,
                                 exp.less, exp.equal, exp.greater, exp.div_zero,
                                 got.less, got.equal, got.greater, got.div_zero);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("q24_8_fixed_point_alu_core_tb: FAIL");
            $finish;
        end
    end

    // Reset, run the tests in turn, then settle and report
    initial
    begin
        int codes_hit;
        mismatch_count = 0;
        checked_count  = 0;
        cycle_count    = 0;
        items_sent     = 0;
        div_zero_sent  = 0;
        burst_left     = 0;
        gaps_on        = 1'b0;
        recv_mode      = RECV_FREE;
        foreach (code_seen[i])
            code_seen[i] = 0;
        rst_n           <= 1'b0;
        op_ch.valid     <= 1'b0;
        op_ch.command   <= '0;
        op_ch.operand_a <= '0;
        op_ch.operand_b <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_edge_cases();
        test_random_mix();
        test_full_rate();
        test_output_stall();

        // Watch for stray results after the last expected one
        drain_results();
        repeat (3 * LATENCY) @(posedge clk);

        codes_hit = 0;
        foreach (code_seen[i])
            if (code_seen[i] != 0)
                codes_hit++;
        $display("Summary: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, checked_count, mismatch_count);
        $display("Summary: %0d of %0d command codes used, %0d divides by zero",
                 codes_hit, CMD_CODES, div_zero_sent);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("q24_8_fixed_point_alu_core_tb: PASS");
        else
            $display("q24_8_fixed_point_alu_core_tb: FAIL");
        $finish;
    end

endmodule

/* q24_8_fixed_point_alu_core.f */
+incdir+src
src/q24alu_pkg.sv
src/q24alu_op_if.sv
src/q24alu_res_if.sv
src/q24_8_fixed_point_alu_core.sv
tb/q24_8_fixed_point_alu_core_tb.sv
